@@ hdl/lps_pkg.sv @@
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared constants, mode codes, the controller/datapath command and status
// structs, and the small arithmetic helpers used by the datapath.
// ----------------------------------------------------------------------------
package lps_pkg;

   // Number of LEDs driven and the mask that keeps patterns inside them.
   localparam int unsigned LedCount = 8;
   localparam logic [7:0]  LedMask  = 8'((1 << LedCount) - 1);

   // Random generator constants.
   localparam logic [31:0] LcgMul    = 32'd1664525;
   localparam logic [31:0] LcgAdd    = 32'd1013904223;
   localparam logic [31:0] SeedReset = 32'h00C0_FFEE;

   // Sparkle timing. The hold is taken modulo 1401 of a byte, which is the
   // byte itself, so only the base is added.
   localparam logic [16:0] HoldBase = 17'd100;
   localparam logic [7:0]  GapMod   = 8'd100;

   // Period limits and register reset value.
   localparam logic [16:0] PeriodMin  = 17'd2;
   localparam logic [16:0] PeriodMax  = 17'd65536;
   localparam logic [16:0] BaseReset  = 17'd1000;

   // Display modes.
   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_BOUNCE  = 2'd1,
      MODE_INVERT  = 2'd2,
      MODE_SPARKLE = 2'd3
   } mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // capture a new request
      logic decode;    // button edges and speed toggle
      logic pattern;   // bounce step, or first random step for sparkle
      logic spark;     // sparkle pattern phase
      logic hold;      // sparkle hold period from the second random byte
      logic load_out;  // move the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sparkle;   // tick request while in sparkle mode
      logic clearing;  // sparkle is in its clearing phase
   } status_type;

   // Tick period for the bounce modes, clamped to the legal range.
   function automatic logic [16:0] base_period(input logic [16:0] base, input logic half);
      logic [16:0] c;
      c = half ? (base >> 1) : base;
      if (c < PeriodMin) begin
         c = PeriodMin;
      end
      if (c > PeriodMax) begin
         c = PeriodMax;
      end
      return c;
   endfunction

   // Sparkle gap of 2..100 counts from a random byte, never under two.
   function automatic logic [16:0] gap_period(input logic [7:0] rnd);
      logic [7:0] r;
      if (rnd >= 8'(2 * GapMod)) begin
         r = rnd - 8'(2 * GapMod);
      end else if (rnd >= GapMod) begin
         r = rnd - GapMod;
      end else begin
         r = rnd;
      end
      r = r + 8'd1;
      if (17'(r) < PeriodMin) begin
         return PeriodMin;
      end
      return 17'(r);
   endfunction

endpackage

@@ hdl/lps_ctrl.sv @@
// ----------------------------------------------------------------------------
// LED pattern sequencer controller
// Steps one request through decode, pattern and optional sparkle phases and
// owns the request and result handshakes.
// ----------------------------------------------------------------------------
module lps_ctrl
   import lps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_DECODE  = 6'b000010,
      ST_PATTERN = 6'b000100,
      ST_SPARK   = 6'b001000,
      ST_HOLD    = 6'b010000,
      ST_EMIT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a result when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_PATTERN;
         end
         ST_PATTERN: begin
            cmd.pattern = 1'b1;
            state_in    = status.sparkle ? ST_SPARK : ST_EMIT;
         end
         ST_SPARK: begin
            cmd.spark = 1'b1;
            state_in  = status.clearing ? ST_EMIT : ST_HOLD;
         end
         ST_HOLD: begin
            cmd.hold = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid is set on load and cleared when the result is taken.
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/lps_datapath.sv @@
// ----------------------------------------------------------------------------
// LED pattern sequencer datapath
// Holds the sequencer state, the random generator, the result being built and
// the output register, and acts on the commands of the controller.
// ----------------------------------------------------------------------------
module lps_datapath
   import lps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_kind,
   input  logic        req_mode_button_one,
   input  logic        req_mode_button_two,
   input  logic        req_mode_button_three,
   input  logic        req_speed_button,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data,
   output logic [7:0]  rsp_led_mask,
   output logic        rsp_led_write,
   output logic [16:0] rsp_period_counts,
   output logic        rsp_period_set
);

   // Sequencer state.
   logic [16:0] base_counts_ff, base_counts_in;
   mode_type    mode_ff, mode_in;
   logic [2:0]  position_ff, position_in;
   logic        moving_up_ff, moving_up_in;
   logic        half_period_ff, half_period_in;
   logic        clearing_ff, clearing_in;
   logic [7:0]  pattern_ff, pattern_in;
   logic [31:0] seed_ff, seed_in;
   logic [3:0]  prev_levels_ff, prev_levels_in;

   // Captured request.
   logic        kind_ff, kind_in;
   logic [3:0]  levels_ff, levels_in;

   // Result being built.
   logic [7:0]  res_leds_ff, res_leds_in;
   logic        res_lw_ff, res_lw_in;
   logic [16:0] res_per_ff, res_per_in;
   logic        res_ps_ff, res_ps_in;

   // Output register.
   logic [7:0]  out_leds_ff, out_leds_in;
   logic        out_lw_ff, out_lw_in;
   logic [16:0] out_per_ff, out_per_in;
   logic        out_ps_ff, out_ps_in;

   logic [31:0] lcg_next;
   logic [7:0]  rnd_byte;
   logic [7:0]  one_hot;
   logic [7:0]  cleared;
   logic        edge_speed, edge_one, edge_two, edge_three;

   // One generator step; the byte in use is the top of the current seed.
   assign lcg_next = seed_ff * LcgMul + LcgAdd;
   assign rnd_byte = seed_ff[31:24];

   // Falling edges against the previous levels.
   assign edge_speed = prev_levels_ff[0] && !levels_ff[0];
   assign edge_one   = prev_levels_ff[1] && !levels_ff[1];
   assign edge_two   = prev_levels_ff[2] && !levels_ff[2];
   assign edge_three = prev_levels_ff[3] && !levels_ff[3];

   assign one_hot = 8'(1) << position_ff;
   assign cleared = pattern_ff & (pattern_ff - 8'd1);

   assign status.sparkle  = !kind_ff && (mode_ff == MODE_SPARKLE);
   assign status.clearing = clearing_ff;

   always_comb begin
      base_counts_in = base_counts_ff;
      mode_in        = mode_ff;
      position_in    = position_ff;
      moving_up_in   = moving_up_ff;
      half_period_in = half_period_ff;
      clearing_in    = clearing_ff;
      pattern_in     = pattern_ff;
      seed_in        = seed_ff;
      prev_levels_in = prev_levels_ff;
      kind_in        = kind_ff;
      levels_in      = levels_ff;
      res_leds_in    = res_leds_ff;
      res_lw_in      = res_lw_ff;
      res_per_in     = res_per_ff;
      res_ps_in      = res_ps_ff;
      out_leds_in    = out_leds_ff;
      out_lw_in      = out_lw_ff;
      out_per_in     = out_per_ff;
      out_ps_in      = out_ps_ff;

      // Register write.
      if (csr_write_enable) begin
         base_counts_in = csr_write_data;
      end

      // Capture the request and clear the result.
      if (cmd.start) begin
         kind_in     = req_kind;
         levels_in   = {req_mode_button_three, req_mode_button_two,
                        req_mode_button_one, req_speed_button};
         res_leds_in = '0;
         res_lw_in   = 1'b0;
         res_per_in  = '0;
         res_ps_in   = 1'b0;
      end

      // Button edges; later mode buttons win over earlier ones.
      if (cmd.decode) begin
         if (kind_ff) begin
            half_period_in    = half_period_ff ^ edge_speed;
            prev_levels_in[0] = levels_ff[0];
            if (edge_speed && (mode_ff == MODE_BOUNCE || mode_ff == MODE_INVERT)) begin
               res_per_in = base_period(base_counts_ff, !half_period_ff);
               res_ps_in  = 1'b1;
            end
         end else begin
            prev_levels_in[3:1] = levels_ff[3:1];
            if (edge_one || edge_two) begin
               position_in  = '0;
               moving_up_in = 1'b1;
               res_per_in   = base_period(base_counts_ff, half_period_ff);
               res_ps_in    = 1'b1;
            end
            if (edge_three) begin
               mode_in     = MODE_SPARKLE;
               clearing_in = 1'b0;
            end else if (edge_two) begin
               mode_in = MODE_INVERT;
            end else if (edge_one) begin
               mode_in = MODE_BOUNCE;
            end
         end
      end

      // Bounce display and walk, or the first random step of sparkle.
      if (cmd.pattern && !kind_ff) begin
         if (mode_ff == MODE_BOUNCE || mode_ff == MODE_INVERT) begin
            res_leds_in = (mode_ff == MODE_BOUNCE) ? (one_hot & LedMask) : (~one_hot & LedMask);
            res_lw_in   = 1'b1;
            if (moving_up_ff) begin
               if (position_ff >= 3'(LedCount - 1)) begin
                  moving_up_in = 1'b0;
                  position_in  = 3'(LedCount - 2);
               end else begin
                  position_in = position_ff + 3'd1;
               end
            end else begin
               if (position_ff == 3'd0) begin
                  moving_up_in = 1'b1;
                  position_in  = 3'd1;
               end else begin
                  position_in = position_ff - 3'd1;
               end
            end
         end else if (mode_ff == MODE_SPARKLE) begin
            seed_in = lcg_next;
         end
      end

      // Sparkle: new pattern, clear one bit, or end of the clearing run.
      if (cmd.spark) begin
         if (!clearing_ff) begin
            pattern_in  = rnd_byte & LedMask;
            res_leds_in = rnd_byte & LedMask;
            res_lw_in   = 1'b1;
            clearing_in = 1'b1;
            seed_in     = lcg_next;
         end else if (pattern_ff != 8'd0) begin
            pattern_in  = cleared;
            res_leds_in = cleared;
            res_lw_in   = 1'b1;
            res_per_in  = gap_period(rnd_byte);
            res_ps_in   = 1'b1;
         end else begin
            res_per_in  = gap_period(rnd_byte);
            res_ps_in   = 1'b1;
            clearing_in = 1'b0;
         end
      end

      // Hold time of a new sparkle pattern.
      if (cmd.hold) begin
         res_per_in = HoldBase + 17'(rnd_byte);
         res_ps_in  = 1'b1;
      end

      if (cmd.load_out) begin
         out_leds_in = res_leds_ff;
         out_lw_in   = res_lw_ff;
         out_per_in  = res_per_ff;
         out_ps_in   = res_ps_ff;
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_counts_ff <= BaseReset;
         mode_ff        <= MODE_OFF;
         position_ff    <= '0;
         moving_up_ff   <= 1'b1;
         half_period_ff <= 1'b0;
         clearing_ff    <= 1'b0;
         pattern_ff     <= '0;
         seed_ff        <= SeedReset;
         prev_levels_ff <= '1;
      end else begin
         base_counts_ff <= base_counts_in;
         mode_ff        <= mode_in;
         position_ff    <= position_in;
         moving_up_ff   <= moving_up_in;
         half_period_ff <= half_period_in;
         clearing_ff    <= clearing_in;
         pattern_ff     <= pattern_in;
         seed_ff        <= seed_in;
         prev_levels_ff <= prev_levels_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      levels_ff   <= levels_in;
      res_leds_ff <= res_leds_in;
      res_lw_ff   <= res_lw_in;
      res_per_ff  <= res_per_in;
      res_ps_ff   <= res_ps_in;
      out_leds_ff <= out_leds_in;
      out_lw_ff   <= out_lw_in;
      out_per_ff  <= out_per_in;
      out_ps_ff   <= out_ps_in;
   end

   assign rsp_led_mask      = out_leds_ff;
   assign rsp_led_write     = out_lw_ff;
   assign rsp_period_counts = out_per_ff;
   assign rsp_period_set    = out_ps_ff;

endmodule

@@ hdl/led_pattern_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// LED pattern sequencer core
// Top level: controller and datapath of the eight-LED pattern sequencer.
// ----------------------------------------------------------------------------
// Each request is a timer tick or a speed button sample and yields exactly one
// result holding the LED mask to write and the tick period to load. A request
// is accepted in idle and then passes through the controller's decode and
// pattern steps to emit, which waits while the output register is full and
// stalled, before the next request is taken. A sparkle clearing tick adds a
// spark step and a tick that draws a new sparkle pattern adds spark and hold
// steps, one step per random number drawn, as each draw advances the seed. A
// finished result waits in the output register while the next request is
// taken. The base period register may be written at any time the block is
// idle and takes effect on the next request.
module led_pattern_sequencer_core
   import lps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic        req_mode_button_one,
   input  logic        req_mode_button_two,
   input  logic        req_mode_button_three,
   input  logic        req_speed_button,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_led_mask,
   output logic        rsp_led_write,
   output logic [16:0] rsp_period_counts,
   output logic        rsp_period_set,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencing control.
   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // State, random generator and result registers.
   lps_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_kind              (req_kind),
      .req_mode_button_one   (req_mode_button_one),
      .req_mode_button_two   (req_mode_button_two),
      .req_mode_button_three (req_mode_button_three),
      .req_speed_button      (req_speed_button),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .rsp_led_mask          (rsp_led_mask),
      .rsp_led_write         (rsp_led_write),
      .rsp_period_counts     (rsp_period_counts),
      .rsp_period_set        (rsp_period_set)
   );

   // A result that writes no LEDs carries an empty mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_led_write || rsp_led_mask == 8'd0))
      else $error("LED mask set without LED write");

   // A period is either absent or inside the legal range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_period_set ? (rsp_period_counts >= PeriodMin &&
                     rsp_period_counts <= PeriodMax) : (rsp_period_counts == 17'd0)))
      else $error("Period out of range or set without period_set");

   // After a request is taken the block is busy for the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Request taken while a previous one is in progress");

endmodule

@@ tb/tb_led_pattern_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// LED pattern sequencer core testbench
// Drives tick and speed-button requests into the sequencer and compares
// every result with a cycle-free predictor of the LED and period outputs.
// A directed opening covers idle, bounce, inverted bounce, sparkle and speed
// toggles. Random phases follow, all but the first with a new base period.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// One result of the sequencer, in port order.
typedef struct packed {
   logic [7:0]  led_mask;
   logic        led_write;
   logic [16:0] period_counts;
   logic        period_set;
} led_result_type;

// Tracks the sequencer state, predicts the result of each accepted request
// and checks the results in order.
class led_pattern_tracker;
   localparam logic [31:0] RandMul  = 32'd1664525;
   localparam logic [31:0] RandAdd  = 32'd1013904223;
   localparam logic [7:0]  LedsUsed = 8'hFF;
   localparam logic [16:0] HoldMin  = 17'd100;
   localparam logic [7:0]  GapSpan  = 8'd100;

   logic [16:0]       base_counts;
   lps_pkg::mode_type mode;
   logic [2:0]        position;
   logic              moving_up;
   logic              half_period;
   logic              clearing;
   logic [7:0]        sparkle_bits;
   logic [31:0]       seed;
   logic [3:0]        levels;
   led_result_type    results_due[$];
   int unsigned       errors;
   int unsigned       checked;

   function new();
      base_counts  = 17'd1000;
      mode         = lps_pkg::MODE_OFF;
      position     = 3'd0;
      moving_up    = 1'b1;
      half_period  = 1'b0;
      clearing     = 1'b0;
      sparkle_bits = 8'd0;
      seed         = 32'h00C0_FFEE;
      levels       = 4'hF;
      errors       = 0;
      checked      = 0;
   endfunction

   // Next byte of the sparkle random sequence.
   function logic [7:0] draw_byte();
      seed = seed * RandMul + RandAdd;
      return seed[31:24];
   endfunction

   // A period is never shorter than two counts.
   function logic [16:0] min_two(input logic [16:0] counts);
      return (counts < 17'd2) ? 17'd2 : counts;
   endfunction

   // Tick period of the bounce modes.
   function logic [16:0] bounce_period();
      logic [16:0] counts;
      counts = half_period ? (base_counts >> 1) : base_counts;
      if (counts > 17'd65536) begin
         counts = 17'd65536;
      end
      return min_two(counts);
   endfunction

   // Move the bounce position one step, turning at both ends.
   function void step_position();
      if (moving_up) begin
         if (position >= 3'(lps_pkg::LedCount - 1)) begin
            moving_up = 1'b0;
            position  = 3'(lps_pkg::LedCount - 2);
         end else begin
            position = position + 3'd1;
         end
      end else if (position == 3'd0) begin
         moving_up = 1'b1;
         position  = 3'd1;
      end else begin
         position = position - 3'd1;
      end
   endfunction

   // Work out the result of one accepted request and queue it.
   function void note_request(input logic kind, input logic b1, input logic b2,
                              input logic b3, input logic bs);
      led_result_type want;
      logic [7:0]     one_hot;
      want = '0;
      if (kind) begin
         // Speed sample: a falling edge toggles the half period.
         if (levels[0] && !bs) begin
            half_period = !half_period;
            if (mode == lps_pkg::MODE_BOUNCE || mode == lps_pkg::MODE_INVERT) begin
               want.period_counts = bounce_period();
               want.period_set    = 1'b1;
            end
         end
         levels[0] = bs;
      end else begin
         // Mode button edges, checked in order so that the last one wins.
         if (levels[1] && !b1) begin
            mode               = lps_pkg::MODE_BOUNCE;
            position           = 3'd0;
            moving_up          = 1'b1;
            want.period_counts = bounce_period();
            want.period_set    = 1'b1;
         end
         if (levels[2] && !b2) begin
            mode               = lps_pkg::MODE_INVERT;
            position           = 3'd0;
            moving_up          = 1'b1;
            want.period_counts = bounce_period();
            want.period_set    = 1'b1;
         end
         if (levels[3] && !b3) begin
            mode     = lps_pkg::MODE_SPARKLE;
            clearing = 1'b0;
         end
         levels[3:1] = {b3, b2, b1};

         // Pattern of the current mode.
         case (mode)
            lps_pkg::MODE_BOUNCE, lps_pkg::MODE_INVERT: begin
               one_hot        = 8'd1 << position;
               want.led_mask  = (mode == lps_pkg::MODE_BOUNCE) ? (one_hot & LedsUsed)
                                                               : (~one_hot & LedsUsed);
               want.led_write = 1'b1;
               step_position();
            end
            lps_pkg::MODE_SPARKLE: begin
               if (!clearing) begin
                  // New random pattern, held for 100 plus a random byte.
                  sparkle_bits       = draw_byte() & LedsUsed;
                  want.led_mask      = sparkle_bits;
                  want.led_write     = 1'b1;
                  want.period_counts = min_two(HoldMin + 17'(draw_byte()));
                  want.period_set    = 1'b1;
                  clearing           = 1'b1;
               end else if (sparkle_bits != 8'd0) begin
                  // Clear the lowest lit LED.
                  sparkle_bits       = sparkle_bits & (sparkle_bits - 8'd1);
                  want.led_mask      = sparkle_bits;
                  want.led_write     = 1'b1;
                  want.period_counts = min_two(17'(draw_byte() % GapSpan) + 17'd1);
                  want.period_set    = 1'b1;
               end else begin
                  // Pattern is empty: only a gap, then a new pattern.
                  want.period_counts = min_two(17'(draw_byte() % GapSpan) + 17'd1);
                  want.period_set    = 1'b1;
                  clearing           = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      results_due.push_back(want);
   endfunction

   task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   // Compare one accepted result with the oldest prediction.
   task check_result(input led_result_type got);
      led_result_type want;
      if (results_due.size() == 0) begin
         report_mismatch($sformatf("result with no request pending: %h", got));
         return;
      end
      want = results_due.pop_front();
      if (got.led_mask !== want.led_mask) begin
         report_mismatch($sformatf("result %0d led_mask %h, predicted %h",
                                   checked, got.led_mask, want.led_mask));
      end
      if (got.led_write !== want.led_write) begin
         report_mismatch($sformatf("result %0d led_write %b, predicted %b",
                                   checked, got.led_write, want.led_write));
      end
      if (got.period_counts !== want.period_counts) begin
         report_mismatch($sformatf("result %0d period_counts %0d, predicted %0d",
                                   checked, got.period_counts, want.period_counts));
      end
      if (got.period_set !== want.period_set) begin
         report_mismatch($sformatf("result %0d period_set %b, predicted %b",
                                   checked, got.period_set, want.period_set));
      end
      checked++;
   endtask
endclass

module tb_led_pattern_sequencer_core;
   import lps_pkg::*;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_SPEED = 1'b1;
   localparam logic PRESSED    = 1'b0;
   localparam logic RELEASED   = 1'b1;
   localparam int   PHASES     = 6;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic        req_mode_button_one;
   logic        req_mode_button_two;
   logic        req_mode_button_three;
   logic        req_speed_button;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_led_mask;
   logic        rsp_led_write;
   logic [16:0] rsp_period_counts;
   logic        rsp_period_set;
   logic        csr_write_enable;
   logic [16:0] csr_write_data;

   led_pattern_tracker tracker;
   bit                 idling_on;
   bit                 hold_off_request;
   logic [2:0]         held_modes;
   logic               held_speed;

   led_pattern_sequencer_core DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_mode_button_one   (req_mode_button_one),
      .req_mode_button_two   (req_mode_button_two),
      .req_mode_button_three (req_mode_button_three),
      .req_speed_button      (req_speed_button),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_led_mask          (rsp_led_mask),
      .rsp_led_write         (rsp_led_write),
      .rsp_period_counts     (rsp_period_counts),
      .rsp_period_set        (rsp_period_set),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   always #2 clock = ~clock;

   // Offer one request, with a random gap first when idling is on, and wait until it is taken.
   task automatic send_request(input logic kind, input logic b1, input logic b2,
                               input logic b3, input logic bs);
      while (idling_on && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_kind              <= kind;
      req_mode_button_one   <= b1;
      req_mode_button_two   <= b2;
      req_mode_button_three <= b3;
      req_speed_button      <= bs;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      tracker.note_request(kind, b1, b2, b3, bs);
   endtask

   // Stop offering and let every pending result come out.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (tracker.results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   // Load a new base period while the block is idle.
   task automatic write_base_counts(input logic [16:0] value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.base_counts = value;
   endtask

   // A random request: mostly realistic button presses and releases,
   // sometimes pure noise on every field.
   task automatic random_request();
      logic [4:0] noise;
      logic       kind;
      logic [2:0] modes;
      logic       speed;
      int         i;
      if ($urandom_range(99) < 10) begin
         noise = 5'($urandom);
         send_request(noise[4], noise[3], noise[2], noise[1], noise[0]);
      end else begin
         kind = ($urandom_range(99) < 25);
         if (kind == KIND_SPEED) begin
            if ($urandom_range(99) < 45) begin
               held_speed = ~held_speed;
            end
            modes = 3'($urandom);
            speed = held_speed;
         end else begin
            // Pressed buttons are soon released, released ones rarely pressed.
            for (i = 0; i < 3; i++) begin
               if (held_modes[i] == PRESSED) begin
                  if ($urandom_range(99) < 60) begin
                     held_modes[i] = RELEASED;
                  end
               end else if ($urandom_range(99) < 3) begin
                  held_modes[i] = PRESSED;
               end
            end
            modes = held_modes;
            speed = 1'($urandom);
         end
         send_request(kind, modes[0], modes[1], modes[2], speed);
      end
   endtask

   // A run of random requests, optionally with a long hold-off at the output
   // or a pause until the block has drained.
   task automatic random_phase(input int count, input bit hold_off, input bit pause);
      int n;
      for (n = 0; n < count; n++) begin
         if (hold_off && n == 10) begin
            hold_off_request = 1'b1;
         end
         if (pause && n == count / 2) begin
            wait_for_results();
         end
         random_request();
      end
   endtask

   // Directed opening: idle, speed toggles, a full bounce sweep, inverted
   // bounce, all three mode buttons at once and some sparkle steps.
   task automatic directed_part();
      send_request(KIND_TICK, RELEASED, RELEASED, RELEASED, RELEASED);
      send_request(KIND_SPEED, RELEASED, RELEASED, RELEASED, PRESSED);
      send_request(KIND_SPEED, RELEASED, RELEASED, RELEASED, RELEASED);
      send_request(KIND_TICK, PRESSED, RELEASED, RELEASED, RELEASED);
      repeat (8) send_request(KIND_TICK, RELEASED, RELEASED, RELEASED, PRESSED);
      send_request(KIND_SPEED, PRESSED, PRESSED, PRESSED, PRESSED);
      send_request(KIND_SPEED, RELEASED, RELEASED, RELEASED, RELEASED);
      send_request(KIND_TICK, RELEASED, PRESSED, RELEASED, RELEASED);
      repeat (2) send_request(KIND_TICK, RELEASED, RELEASED, RELEASED, RELEASED);
      send_request(KIND_TICK, PRESSED, PRESSED, PRESSED, RELEASED);
      send_request(KIND_SPEED, RELEASED, RELEASED, RELEASED, PRESSED);
      send_request(KIND_SPEED, RELEASED, RELEASED, RELEASED, RELEASED);
      repeat (4) send_request(KIND_TICK, RELEASED, RELEASED, RELEASED, RELEASED);
   endtask

   // Result side: check accepted results and stall at random, or for a long
   // stretch when asked.
   initial begin : result_side
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            tracker.check_result({rsp_led_mask, rsp_led_write,
                                  rsp_period_counts, rsp_period_set});
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = 200;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idling_on && ($urandom_range(99) < 36);
         end
      end
   end

   // Request side and overall sequence.
   initial begin : request_side
      logic [16:0] phase_base [PHASES];
      int          p;
      tracker               = new();
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_kind              = KIND_TICK;
      req_mode_button_one   = RELEASED;
      req_mode_button_two   = RELEASED;
      req_mode_button_three = RELEASED;
      req_speed_button      = RELEASED;
      csr_write_enable      = 1'b0;
      csr_write_data        = 17'd0;
      idling_on             = 1'b1;
      hold_off_request      = 1'b0;
      held_modes            = {3{RELEASED}};
      held_speed            = RELEASED;
      phase_base[0]         = 17'd1;
      phase_base[1]         = 17'd65536;
      phase_base[2]         = 17'd2;
      phase_base[3]         = 17'd3;
      phase_base[4]         = 17'($urandom_range(65536, 1));
      phase_base[5]         = 17'd65535;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of the base period first.
      directed_part();
      random_phase(80, 1'b1, 1'b0);

      for (p = 0; p < PHASES - 1; p++) begin
         write_base_counts(phase_base[p]);
         idling_on = (p != 2);
         random_phase(80, 1'b0, (p == 0));
      end

      idling_on = 1'b1;
      wait_for_results();
      if (tracker.errors == 0) begin
         $display("PASS led_pattern_sequencer_core");
      end else begin
         $display("FAIL led_pattern_sequencer_core");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin : run_limit
      #2000000;
      $display("FAIL led_pattern_sequencer_core");
      $finish;
   end

endmodule

@@ led_pattern_sequencer_core.f @@
hdl/lps_pkg.sv
hdl/lps_ctrl.sv
hdl/lps_datapath.sv
hdl/led_pattern_sequencer_core.sv
tb/tb_led_pattern_sequencer_core.sv
